>>> sv/mqm_pkg.sv
// Shared types and codes for the multi-queue mailbox.
`default_nettype none
package mqm_pkg;

  // Fixed field widths.
  localparam int OpW   = 3;
  localparam int IdW   = 8;
  localparam int LenW  = 12;
  localparam int ByteW = 8;
  localparam int StW   = 4;

  // Operation codes.
  localparam logic [OpW-1:0] OpAlloc     = 3'd0;
  localparam logic [OpW-1:0] OpSendStart = 3'd1;
  localparam logic [OpW-1:0] OpSendByte  = 3'd2;
  localparam logic [OpW-1:0] OpReceive   = 3'd3;
  localparam logic [OpW-1:0] OpDestroy   = 3'd4;

  // Status codes.
  localparam logic [StW-1:0] StOk        = 4'd0;
  localparam logic [StW-1:0] StBadId     = 4'd1;
  localparam logic [StW-1:0] StFull      = 4'd2;
  localparam logic [StW-1:0] StBadLen    = 4'd3;
  localparam logic [StW-1:0] StEmpty     = 4'd4;
  localparam logic [StW-1:0] StBufSmall  = 4'd5;
  localparam logic [StW-1:0] StNotEmpty  = 4'd6;
  localparam logic [StW-1:0] StNoneFree  = 4'd7;
  localparam logic [StW-1:0] StNoSend    = 4'd8;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic exec;     // execute the input word presented this cycle
    logic rx_step;  // emit the next receive byte into the output register
  } mqm_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free; // output register empty or being taken this cycle
    logic rx_go;    // current input word is a receive that passes its checks
    logic rx_last;  // byte being emitted is the final one of the receive
  } mqm_sts_t;

endpackage
`default_nettype wire

>>> sv/mqm_ctrl.sv
// Controller state machine that sequences input words and receive bursts.
`default_nettype none
module mqm_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire mqm_pkg::mqm_sts_t sts_i,
  output mqm_pkg::mqm_cmd_t      cmd_o
);
  import mqm_pkg::*;

  typedef enum logic {
    S_IDLE,
    S_RX
  } state_e;

  state_e state_q;

  // Commands follow from the state and the datapath status.
  always_comb begin
    in_ready_o     = (state_q == S_IDLE) && sts_i.out_free;
    cmd_o.exec     = in_ready_o && in_valid_i;
    cmd_o.rx_step  = (state_q == S_RX) && sts_i.out_free;
  end

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (cmd_o.exec && sts_i.rx_go) begin
            state_q <= S_RX;
          end
        end
        S_RX: begin
          if (cmd_o.rx_step && sts_i.rx_last) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

>>> sv/mqm_dp.sv
// Datapath: queue pointers, send state, message memory and output register.
`default_nettype none
module mqm_dp #(
  parameter int NUM_QUEUES        = 2,
  parameter int SLOTS_PER_QUEUE   = 10,
  parameter int MAX_MESSAGE_BYTES = 256,
  parameter int RECEIVE_BYTES     = 10,
  localparam int QIW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire mqm_pkg::mqm_cmd_t                   cmd_i,
  output mqm_pkg::mqm_sts_t                        sts_o,
  input  wire logic [mqm_pkg::OpW-1:0]             operation_i,
  input  wire logic signed [mqm_pkg::IdW-1:0]      queue_id_i,
  input  wire logic [mqm_pkg::LenW-1:0]            length_i,
  input  wire logic [mqm_pkg::ByteW-1:0]           data_byte_i,
  input  wire logic                                out_ready_i,
  output logic                                     out_valid_o,
  output logic [mqm_pkg::StW-1:0]                  status_o,
  output logic [QIW-1:0]                           granted_queue_o,
  output logic [mqm_pkg::ByteW-1:0]                out_byte_o,
  output logic                                     last_o
);
  import mqm_pkg::*;

  localparam int Keep     = RECEIVE_BYTES - 1;
  localparam int TW       = $clog2(SLOTS_PER_QUEUE);
  localparam int CW       = $clog2(SLOTS_PER_QUEUE + 1) + 1;
  localparam int RW       = $clog2(MAX_MESSAGE_BYTES);
  localparam int LW       = $clog2(RECEIVE_BYTES);
  localparam int MemDepth = NUM_QUEUES * SLOTS_PER_QUEUE * Keep;
  localparam int AW       = $clog2(MemDepth);
  localparam int SlotSpan = SLOTS_PER_QUEUE * Keep;

  localparam logic signed [CW-1:0] CntZero = '0;
  localparam logic signed [CW-1:0] CntOne  = CW'(1);
  localparam logic signed [CW-1:0] CntFull = CW'(SLOTS_PER_QUEUE);
  localparam logic signed [CW-1:0] CntDead = '1;
  localparam logic [TW-1:0] TailLast = TW'(SLOTS_PER_QUEUE - 1);
  localparam logic [LW-1:0] PosKeep  = LW'(Keep);
  localparam logic [LW-1:0] IdxLast  = LW'(RECEIVE_BYTES - 1);
  localparam logic [LenW:0] LenMax   = (LenW + 1)'(MAX_MESSAGE_BYTES);
  localparam logic [LenW:0] LenRx    = (LenW + 1)'(RECEIVE_BYTES);
  localparam logic [IdW-1:0] NumQ    = IdW'(NUM_QUEUES);

  // Queue state.
  logic [TW-1:0]        head_q [NUM_QUEUES];
  logic [TW-1:0]        tail_q [NUM_QUEUES];
  logic signed [CW-1:0] fill_q [NUM_QUEUES];
  logic [LW-1:0]        slot_len_q [NUM_QUEUES][SLOTS_PER_QUEUE];

  // Open send.
  logic          open_q;
  logic [QIW-1:0] sq_q;
  logic [RW-1:0] rem_q;
  logic [LW-1:0] pos_q;

  // Receive burst.
  logic [LW-1:0] rx_n_q;
  logic [LW-1:0] rx_idx_q;
  logic          rx_stop_q;
  logic [AW-1:0] rx_addr_q;

  // Message memory.
  logic [ByteW-1:0] mem [MemDepth];
  logic [ByteW-1:0] rd_data_q;

  // Output register.
  logic             ov_q;
  logic [StW-1:0]   ost_q;
  logic [QIW-1:0]   ogq_q;
  logic [ByteW-1:0] obyte_q;
  logic             olast_q;

  logic                 id_ok;
  logic [QIW-1:0]       q;
  logic signed [CW-1:0] cnt;
  logic [TW-1:0]        head_sel;
  logic [LW-1:0]        head_len;
  logic                 found;
  logic [QIW-1:0]       gidx;
  logic                 do_alloc, do_start, start_commit, do_byte, byte_commit;
  logic                 do_destroy, rx_go, commit, single;
  logic [QIW-1:0]       cq;
  logic [LW-1:0]        pos_nxt, clen;
  logic [StW-1:0]       res_st;
  logic [ByteW-1:0]     rx_byte;
  logic                 rx_last, rx_more;
  logic                 we, re;
  logic [AW-1:0]        waddr, raddr;

  // Queue selection and allocate search.
  always_comb begin
    id_ok    = !queue_id_i[IdW-1] && ({1'b0, queue_id_i[IdW-2:0]} < NumQ);
    q        = id_ok ? queue_id_i[QIW-1:0] : '0;
    cnt      = fill_q[q];
    head_sel = head_q[q];
    head_len = slot_len_q[q][head_sel];
    found    = 1'b0;
    gidx     = '0;
    for (int i = NUM_QUEUES - 1; i >= 0; i--) begin
      if (fill_q[i] == CntZero) begin
        found = 1'b1;
        gidx  = QIW'(i);
      end
    end
  end

  // Operation decode with its checks, in check order.
  always_comb begin
    do_alloc     = 1'b0;
    do_start     = 1'b0;
    do_byte      = 1'b0;
    do_destroy   = 1'b0;
    rx_go        = 1'b0;
    single       = 1'b1;
    res_st       = StOk;
    case (operation_i)
      OpAlloc: begin
        do_alloc = found;
        res_st   = found ? StOk : StNoneFree;
      end
      OpSendStart: begin
        if (!id_ok) begin
          res_st = StBadId;
        end else if (cnt >= CntFull) begin
          res_st = StFull;
        end else if ({1'b0, length_i} >= LenMax) begin
          res_st = StBadLen;
        end else begin
          do_start = 1'b1;
        end
      end
      OpSendByte: begin
        do_byte = open_q;
        res_st  = open_q ? StOk : StNoSend;
      end
      OpReceive: begin
        if (!id_ok) begin
          res_st = StBadId;
        end else if (cnt <= CntZero) begin
          res_st = StEmpty;
        end else if ({1'b0, length_i} < LenRx) begin
          res_st = StBufSmall;
        end else begin
          rx_go  = 1'b1;
          single = 1'b0;
        end
      end
      OpDestroy: begin
        if (!id_ok) begin
          res_st = StBadId;
        end else if (cnt > CntZero) begin
          res_st = StNotEmpty;
        end else begin
          do_destroy = 1'b1;
        end
      end
      default: begin
        single = 1'b0;
      end
    endcase
    pos_nxt      = (pos_q == PosKeep) ? pos_q : pos_q + LW'(1);
    start_commit = do_start && (length_i == '0);
    byte_commit  = do_byte && (rem_q == RW'(1));
    commit       = start_commit || byte_commit;
    cq           = start_commit ? q : sq_q;
    clen         = start_commit ? '0 : pos_nxt;
  end

  // Receive byte shaping: C string cut at the first zero, then zero padded.
  always_comb begin
    rx_byte = (!rx_stop_q && (rx_idx_q < rx_n_q)) ? rd_data_q : '0;
    rx_last = (rx_idx_q == IdxLast);
    rx_more = ({1'b0, rx_idx_q} + (LW + 1)'(1)) < {1'b0, rx_n_q};
  end

  // Memory port control.
  always_comb begin
    we    = cmd_i.exec && do_byte && (pos_q < PosKeep);
    waddr = AW'(sq_q) * AW'(SlotSpan) + AW'(tail_q[sq_q]) * AW'(Keep) + AW'(pos_q);
    re    = 1'b0;
    raddr = rx_addr_q + AW'(1);
    if (cmd_i.exec && rx_go) begin
      re    = (head_len != '0);
      raddr = AW'(q) * AW'(SlotSpan) + AW'(head_sel) * AW'(Keep);
    end else if (cmd_i.rx_step) begin
      re = rx_more;
    end
  end

  // Message memory: one write and one registered read port.
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= data_byte_i;
    end
    if (re) begin
      rd_data_q <= mem[raddr];
    end
  end

  // Slot lengths, written at commit.
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec && commit) begin
      slot_len_q[cq][tail_q[cq]] <= clen;
    end
  end

  // Receive burst payload.
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec && rx_go) begin
      rx_n_q    <= head_len;
      rx_idx_q  <= '0;
      rx_stop_q <= 1'b0;
      rx_addr_q <= raddr;
    end else if (cmd_i.rx_step) begin
      rx_idx_q  <= rx_idx_q + LW'(1);
      rx_stop_q <= rx_stop_q || (rx_byte == '0);
      rx_addr_q <= raddr;
    end
  end

  // Queue pointers, counts and send state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_QUEUES; i++) begin
        head_q[i] <= '0;
        tail_q[i] <= '0;
        fill_q[i] <= CntZero;
      end
      open_q <= 1'b0;
      sq_q   <= '0;
      rem_q  <= '0;
      pos_q  <= '0;
    end else if (cmd_i.exec) begin
      if (do_alloc) begin
        head_q[gidx] <= '0;
        tail_q[gidx] <= '0;
      end
      // A zero-length send commits at once and leaves nothing open.
      if (do_start) begin
        open_q <= !start_commit;
        sq_q   <= q;
        rem_q  <= length_i[RW-1:0];
        pos_q  <= '0;
      end
      if (do_byte) begin
        pos_q <= pos_nxt;
        rem_q <= rem_q - RW'(1);
        if (byte_commit) begin
          open_q <= 1'b0;
        end
      end
      if (commit) begin
        tail_q[cq] <= (tail_q[cq] == TailLast) ? '0 : tail_q[cq] + TW'(1);
        fill_q[cq] <= fill_q[cq] + CntOne;
      end
      if (rx_go) begin
        head_q[q] <= (head_sel == TailLast) ? '0 : head_sel + TW'(1);
        fill_q[q] <= cnt - CntOne;
      end
      if (do_destroy) begin
        fill_q[q] <= CntDead;
      end
    end
  end

  // Output register valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if ((cmd_i.exec && single) || cmd_i.rx_step) begin
      ov_q <= 1'b1;
    end else if (out_ready_i) begin
      ov_q <= 1'b0;
    end
  end

  // Output register payload.
  always_ff @(posedge clk_i) begin
    if (cmd_i.rx_step) begin
      ost_q   <= StOk;
      ogq_q   <= '0;
      obyte_q <= rx_byte;
      olast_q <= rx_last;
    end else if (cmd_i.exec && single) begin
      ost_q   <= res_st;
      ogq_q   <= do_alloc ? gidx : '0;
      obyte_q <= '0;
      olast_q <= 1'b1;
    end
  end

  assign sts_o.out_free  = !ov_q || out_ready_i;
  assign sts_o.rx_go     = rx_go;
  assign sts_o.rx_last   = rx_last;
  assign out_valid_o     = ov_q;
  assign status_o        = ost_q;
  assign granted_queue_o = ogq_q;
  assign out_byte_o      = obyte_q;
  assign last_o          = olast_q;

endmodule
`default_nettype wire

>>> sv/multi_queue_mailbox.sv
// Top level of the multi-queue mailbox: controller plus datapath.
//
// Input channel (in_valid_i/in_ready_o) carries one command word: operation,
// queue id, length and data byte. Output channel (out_valid_o/out_ready_i)
// carries result words: status, granted queue, byte and a last flag.
// Every defined command except a successful receive yields exactly one result
// word, registered and visible the cycle after the command is accepted; such
// commands are accepted one per cycle while the output register drains.
// A successful receive yields RECEIVE_BYTES result words, last set on the
// final one. The first passes through the registered read port of the message
// memory and then the output register; the rest follow one per cycle while
// the receiver takes them. No command is accepted until the final word is in
// the output register. Unused operation codes are accepted and yield no result.
// When the receiver stalls, the output register holds its word and input
// acceptance stops until that word is taken.
// Reset clears all queue pointers and counts and closes any open send;
// message memory contents are not cleared and need no clearing pass.
`default_nettype none
module multi_queue_mailbox #(
  parameter int NUM_QUEUES        = 2,
  parameter int SLOTS_PER_QUEUE   = 10,
  parameter int MAX_MESSAGE_BYTES = 256,
  parameter int RECEIVE_BYTES     = 10,
  localparam int QIW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           in_valid_i,
  output logic                                in_ready_o,
  input  wire logic [mqm_pkg::OpW-1:0]        operation_i,
  input  wire logic signed [mqm_pkg::IdW-1:0] queue_id_i,
  input  wire logic [mqm_pkg::LenW-1:0]       length_i,
  input  wire logic [mqm_pkg::ByteW-1:0]      data_byte_i,
  output logic                                out_valid_o,
  input  wire logic                           out_ready_i,
  output logic [mqm_pkg::StW-1:0]             status_o,
  output logic [QIW-1:0]                      granted_queue_o,
  output logic [mqm_pkg::ByteW-1:0]           out_byte_o,
  output logic                                last_o
);
  import mqm_pkg::*;

  mqm_cmd_t cmd;
  mqm_sts_t sts;

  // Sequencing.
  mqm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Queue storage and result formation.
  mqm_dp #(
    .NUM_QUEUES        (NUM_QUEUES),
    .SLOTS_PER_QUEUE   (SLOTS_PER_QUEUE),
    .MAX_MESSAGE_BYTES (MAX_MESSAGE_BYTES),
    .RECEIVE_BYTES     (RECEIVE_BYTES)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .operation_i     (operation_i),
    .queue_id_i      (queue_id_i),
    .length_i        (length_i),
    .data_byte_i     (data_byte_i),
    .out_ready_i     (out_ready_i),
    .out_valid_o     (out_valid_o),
    .status_o        (status_o),
    .granted_queue_o (granted_queue_o),
    .out_byte_o      (out_byte_o),
    .last_o          (last_o)
  );

endmodule
`default_nettype wire

>>> sv/mqm_checker.sv
// Port-level checker for the multi-queue mailbox and its bind statement.
`default_nettype none
module mqm_checker (
  input wire logic                      clk_i,
  input wire logic                      rst_ni,
  input wire logic                      in_valid_i,
  input wire logic                      in_ready_o,
  input wire logic [mqm_pkg::OpW-1:0]   operation_i,
  input wire logic                      out_valid_o,
  input wire logic                      out_ready_i,
  input wire logic [mqm_pkg::StW-1:0]   status_o,
  input wire logic [mqm_pkg::ByteW-1:0] out_byte_o,
  input wire logic                      last_o
);
  import mqm_pkg::*;

  // A stalled result word holds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      out_valid_o && $stable(status_o) && $stable(out_byte_o) && $stable(last_o))
    else $error("result word changed while stalled");

  // A nonzero byte only comes from a receive, and never on its final word.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_byte_o != '0) |-> (status_o == StOk) && !last_o)
    else $error("nonzero byte outside a receive body");

  // A single-result command shows its result in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (operation_i != OpReceive) &&
      (operation_i <= OpDestroy) |=> out_valid_o)
    else $error("single result missing after accept");

  // No command is taken while a result word is stalled.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |-> !in_ready_o)
    else $error("input accepted over a stalled result");

endmodule

bind multi_queue_mailbox mqm_checker u_mqm_checker (.*);
`default_nettype wire

>>> dv/tb_multi_queue_mailbox.sv
// Self-checking testbench for the multi-queue mailbox: directed and random command words.
module tb_multi_queue_mailbox;
  timeunit 1ns;
  timeprecision 1ps;

  import mqm_pkg::*;

  localparam int NQ        = 2;
  localparam int SLOTS     = 10;
  localparam int MAX_LEN   = 256;
  localparam int RX_BYTES  = 10;
  localparam int KEEP      = RX_BYTES - 1;
  localparam int QW        = 1;
  localparam int TARGET    = 205;
  localparam int CALM_FROM = 180;
  localparam int DRAIN_AT  = 130;
  localparam int QUIET_MAX = 1000;

  // Operation code that the block ignores.
  localparam logic [OpW-1:0] OpSpare = 3'd7;

  // One result word as the block should produce it.
  typedef struct {
    logic [StW-1:0]   status;
    logic [QW-1:0]    granted;
    logic [ByteW-1:0] data;
    logic             last;
  } result_word_t;

  // Predicts the result words of each accepted command and checks them in order.
  class msg_queue_scoreboard;
    result_word_t     expected_words[$];
    int               errors;
    int               head [NQ];
    int               tail [NQ];
    int               fill [NQ];
    logic [ByteW-1:0] slot_data [NQ][SLOTS][KEEP];
    int               slot_len [NQ][SLOTS];
    bit               data_ok [NQ][SLOTS][KEEP];
    bit               len_ok [NQ][SLOTS];
    bit               sending;
    int               send_q;
    int               send_left;
    int               send_pos;

    function void add_word(logic [StW-1:0] st, int q, logic [ByteW-1:0] b, bit l);
      result_word_t w;
      w.status  = st;
      w.granted = q[QW-1:0];
      w.data    = b;
      w.last    = l;
      expected_words.push_back(w);
    endfunction

    // The open message lands in the tail slot of its queue.
    function void commit_message();
      int t;
      t = tail[send_q];
      slot_len[send_q][t] = (send_pos < KEEP) ? send_pos : KEEP;
      len_ok[send_q][t] = 1'b1;
      tail[send_q] = (t + 1) % SLOTS;
      fill[send_q]++;
      sending = 1'b0;
    endfunction

    // True when a receive would pop a message whose bytes were never all stored.
    function bit reads_unwritten(logic signed [IdW-1:0] id, logic [LenW-1:0] len);
      int q;
      int h;
      int i;
      if (id < 0 || id >= NQ || len < RX_BYTES) return 1'b0;
      q = int'(id);
      if (fill[q] <= 0) return 1'b0;
      h = head[q];
      if (!len_ok[q][h]) return 1'b1;
      for (i = 0; i < slot_len[q][h]; i++) begin
        if (!data_ok[q][h][i]) return 1'b1;
      end
      return 1'b0;
    endfunction

    function void note_command(logic [OpW-1:0] op, logic signed [IdW-1:0] id,
                               logic [LenW-1:0] len, logic [ByteW-1:0] db);
      bit               id_ok;
      bit               stop;
      int               q;
      int               h;
      int               n;
      int               i;
      logic [ByteW-1:0] b;
      id_ok = (id >= 0) && (id < NQ);
      q = id_ok ? int'(id) : 0;
      case (op)
        OpAlloc: begin
          // The first queue with a zero count is granted and rewound.
          for (i = 0; i < NQ; i++) begin
            if (fill[i] == 0) begin
              head[i] = 0;
              tail[i] = 0;
              add_word(StOk, i, '0, 1'b1);
              return;
            end
          end
          add_word(StNoneFree, 0, '0, 1'b1);
        end
        OpSendStart: begin
          if (!id_ok) add_word(StBadId, 0, '0, 1'b1);
          else if (fill[q] >= SLOTS) add_word(StFull, 0, '0, 1'b1);
          else if (len >= MAX_LEN) add_word(StBadLen, 0, '0, 1'b1);
          else begin
            sending   = 1'b1;
            send_q    = q;
            send_left = int'(len);
            send_pos  = 0;
            if (len == 0) commit_message();
            add_word(StOk, 0, '0, 1'b1);
          end
        end
        OpSendByte: begin
          if (!sending) add_word(StNoSend, 0, '0, 1'b1);
          else begin
            if (send_pos < KEEP) begin
              slot_data[send_q][tail[send_q]][send_pos] = db;
              data_ok[send_q][tail[send_q]][send_pos] = 1'b1;
            end
            send_pos++;
            send_left--;
            if (send_left == 0) commit_message();
            add_word(StOk, 0, '0, 1'b1);
          end
        end
        OpReceive: begin
          if (!id_ok) add_word(StBadId, 0, '0, 1'b1);
          else if (fill[q] <= 0) add_word(StEmpty, 0, '0, 1'b1);
          else if (len < RX_BYTES) add_word(StBufSmall, 0, '0, 1'b1);
          else begin
            // The message comes out as a C string, cut short and zero padded.
            h = head[q];
            n = slot_len[q][h];
            stop = 1'b0;
            for (i = 0; i < RX_BYTES; i++) begin
              b = '0;
              if (!stop && i < n && i < KEEP) b = slot_data[q][h][i];
              if (b == 0) stop = 1'b1;
              add_word(StOk, 0, b, i == RX_BYTES - 1);
            end
            head[q] = (h + 1) % SLOTS;
            fill[q]--;
          end
        end
        OpDestroy: begin
          if (!id_ok) add_word(StBadId, 0, '0, 1'b1);
          else if (fill[q] > 0) add_word(StNotEmpty, 0, '0, 1'b1);
          else begin
            fill[q] = -1;
            add_word(StOk, 0, '0, 1'b1);
          end
        end
        default: ;
      endcase
    endfunction

    function void check_word(logic [StW-1:0] st, logic [QW-1:0] g, logic [ByteW-1:0] b,
                             logic l);
      result_word_t w;
      if (expected_words.size() == 0) begin
        $display("%0t: unexpected word: status %0d queue %0d byte %02h last %0d",
                 $time, st, g, b, l);
        errors++;
        return;
      end
      w = expected_words.pop_front();
      if (st !== w.status || g !== w.granted || b !== w.data || l !== w.last) begin
        $display("%0t: expected status %0d queue %0d byte %02h last %0d,",
                 $time, w.status, w.granted, w.data, w.last);
        $display("%0t:      got status %0d queue %0d byte %02h last %0d",
                 $time, st, g, b, l);
        errors++;
      end
    endfunction

    function int pending();
      return expected_words.size();
    endfunction
  endclass

  logic                  clk_i;
  logic                  rst_ni;
  logic                  in_valid_i;
  logic                  in_ready_o;
  logic [OpW-1:0]        operation_i;
  logic signed [IdW-1:0] queue_id_i;
  logic [LenW-1:0]       length_i;
  logic [ByteW-1:0]      data_byte_i;
  logic                  out_valid_o;
  logic                  out_ready_i;
  logic [StW-1:0]        status_o;
  logic [QW-1:0]         granted_queue_o;
  logic [ByteW-1:0]      out_byte_o;
  logic                  last_o;

  msg_queue_scoreboard sb = new();
  int                  words_sent = 0;
  bit                  calm = 1'b0;
  bit                  src_gaps = 1'b1;

  multi_queue_mailbox #(
    .NUM_QUEUES       (NQ),
    .SLOTS_PER_QUEUE  (SLOTS),
    .MAX_MESSAGE_BYTES(MAX_LEN),
    .RECEIVE_BYTES    (RX_BYTES)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .operation_i    (operation_i),
    .queue_id_i     (queue_id_i),
    .length_i       (length_i),
    .data_byte_i    (data_byte_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .status_o       (status_o),
    .granted_queue_o(granted_queue_o),
    .out_byte_o     (out_byte_o),
    .last_o         (last_o)
  );

  // Free-running clock.
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Every accepted result word is checked against the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      sb.check_word(status_o, granted_queue_o, out_byte_o, last_o);
    end
  end

  // The run ends if neither side moves a word for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_MAX) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet = 0;
      else quiet++;
    end
    $display("Mismatches found");
    $finish;
  end

  // The receiver stalls in random bursts, with stretches of none, until the run calms down.
  initial begin : sink_pacing
    int span;
    bit stalls_on;
    out_ready_i <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    out_ready_i <= 1'b1;
    forever begin
      stalls_on = $urandom_range(0, 2) != 0;
      span = $urandom_range(20, 80);
      repeat (span) begin
        @(posedge clk_i);
        if (stalls_on && !calm && $urandom_range(0, 5) == 0) begin
          out_ready_i <= 1'b0;
          repeat ($urandom_range(1, 17)) @(posedge clk_i);
          out_ready_i <= 1'b1;
        end
      end
    end
  end

  // Present one command word, hold it until accepted, then predict its results.
  task automatic issue(input logic [OpW-1:0] op, input logic signed [IdW-1:0] id,
                       input logic [LenW-1:0] len, input logic [ByteW-1:0] db);
    logic [LenW-1:0] len_use;
    len_use = len;
    // A receive of a partly stored message becomes a short-buffer request instead.
    if (op == OpReceive && sb.reads_unwritten(id, len)) len_use = LenW'(RX_BYTES - 1);
    if (!calm && src_gaps && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    operation_i <= op;
    queue_id_i  <= id;
    length_i    <= len_use;
    data_byte_i <= db;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_command(op, id, len_use, db);
    if (op <= OpDestroy) words_sent++;
  endtask

  // A send start followed by its bytes; now and then the message is left unfinished.
  task automatic send_message();
    int q;
    int len;
    int n;
    int i;
    q = $urandom_range(0, NQ - 1);
    case ($urandom_range(0, 9))
      0: len = 0;
      1: len = $urandom_range(13, 40);
      default: len = $urandom_range(1, 12);
    endcase
    n = len;
    if (len > 0 && $urandom_range(0, 9) == 0) n = $urandom_range(0, len - 1);
    issue(OpSendStart, IdW'(q), LenW'(len), ByteW'($urandom));
    for (i = 0; i < n; i++) begin
      issue(OpSendByte, IdW'($urandom), LenW'($urandom),
            ($urandom_range(0, 7) == 0) ? 8'h00 : ByteW'($urandom_range(1, 255)));
    end
  endtask

  initial begin : stimulus
    logic [ByteW-1:0] pattern [10];
    int               scenario;
    int               i;
    bit               drained;
    pattern = '{8'hFF, 8'h80, 8'h01, 8'h7F, 8'hAA, 8'h55, 8'h0F, 8'hF0, 8'h3C, 8'hC3};
    drained = 1'b0;
    rst_ni      <= 1'b0;
    in_valid_i  <= 1'b0;
    operation_i <= OpAlloc;
    queue_id_i  <= '0;
    length_i    <= '0;
    data_byte_i <= '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed words: field extremes, every operation and the corner cases.
    issue(OpAlloc, 0, 0, 0);
    issue(OpSendStart, 127, 4095, 0);
    issue(OpSendStart, 0, 4095, 0);
    issue(OpSendByte, 0, 0, 8'hFF);
    issue(OpSendStart, 0, 0, 0);
    issue(OpReceive, 0, 9, 0);
    issue(OpReceive, 0, 4095, 0);
    issue(OpReceive, 0, 10, 0);
    issue(OpDestroy, 1, 0, 0);
    issue(OpAlloc, 0, 0, 0);
    issue(OpSendStart, 0, 255, 0);
    // This send replaces the open one and goes to the destroyed queue.
    issue(OpSendStart, 1, 10, 0);
    for (i = 0; i < 10; i++) issue(OpSendByte, 0, 0, pattern[i]);
    issue(OpReceive, 1, 10, 0);
    issue(OpDestroy, -128, 0, 0);
    issue(OpSpare, 0, 0, 0);

    // Random part: mostly complete messages and receives, some noise.
    while (words_sent < TARGET) begin
      if ($urandom_range(0, 9) == 0) src_gaps = !src_gaps;
      if (words_sent >= CALM_FROM) calm = 1'b1;
      if (!drained && words_sent >= DRAIN_AT) begin
        // Hold off new words until every outstanding result has come back.
        drained = 1'b1;
        in_valid_i <= 1'b0;
        do @(posedge clk_i); while (sb.pending() != 0);
      end
      scenario = $urandom_range(0, 99);
      if (scenario < 42) begin
        send_message();
      end else if (scenario < 72) begin
        case ($urandom_range(0, 7))
          0: issue(OpReceive, IdW'($urandom_range(0, NQ - 1)),
                   LenW'($urandom_range(0, RX_BYTES - 1)), '0);
          1, 2: issue(OpReceive, IdW'($urandom_range(0, NQ - 1)),
                      LenW'($urandom_range(RX_BYTES, 4095)), ByteW'($urandom));
          default: issue(OpReceive, IdW'($urandom_range(0, NQ - 1)), LenW'(RX_BYTES),
                         ByteW'($urandom));
        endcase
      end else if (scenario < 80) begin
        issue(OpAlloc, IdW'($urandom), LenW'($urandom), ByteW'($urandom));
      end else if (scenario < 87) begin
        issue(OpDestroy, IdW'($urandom_range(0, NQ - 1)), LenW'($urandom),
              ByteW'($urandom));
      end else begin
        issue(OpW'($urandom_range(0, 7)), IdW'($urandom), LenW'($urandom),
              ByteW'($urandom));
      end
    end

    // Let the last results drain, then report.
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (sb.errors == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule
